// ===== rtl/core/look_elevator_dispatch_defines.svh =====
// assertion macros shared by the dispatch rtl
`ifndef LOOK_ELEVATOR_DISPATCH_DEFINES_SVH
`define LOOK_ELEVATOR_DISPATCH_DEFINES_SVH

// consequent checked in the same cycle
`define LKD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the next cycle
`define LKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lkd_pkg.sv =====
package lkd_pkg;

  localparam int FLOORS_DEF = 8;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLEAR = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] KIND_CAR   = 2'd0;
  localparam logic [1:0] KIND_UP    = 2'd1;
  localparam logic [1:0] KIND_DOWN  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [1:0] MOVE_IDLE = 2'd0;
  localparam logic [1:0] MOVE_UP   = 2'd1;
  localparam logic [1:0] MOVE_DOWN = 2'd2;

  // update and query control broadcast to every cell
  typedef struct packed {
    logic       wr;
    logic       add;
    logic       clear;
    logic [1:0] kind;
    logic [1:0] dir;
  } lkd_ctl_t;

  // answer of the addressed cell, zero from all others
  typedef struct packed {
    logic stop;
    logic above;
    logic below;
  } lkd_res_t;

endpackage

// ===== rtl/core/lkd_cell.sv =====
module lkd_cell
  import lkd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  lkd_ctl_t ctl,
  input  logic     sel,
  input  logic     above_in,
  input  logic     below_in,
  output logic     above_out,
  output logic     below_out,
  output logic     any_call,
  output lkd_res_t res
);

  logic car, up, dn;
  logic car_next, up_next, dn_next;
  logic any_next;
  logic hit;

  assign hit = ctl.wr && sel;

  always_comb begin
    car_next = car;
    up_next  = up;
    dn_next  = dn;
    if (hit && ctl.add) begin
      unique case (ctl.kind)
        KIND_CAR:  car_next = 1'b1;
        KIND_UP:   up_next  = 1'b1;
        KIND_DOWN: dn_next  = 1'b1;
        default:   ;
      endcase
    end else if (hit && ctl.clear) begin
      car_next = 1'b0;
      up_next  = 1'b0;
      dn_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      car <= 1'b0;
      up  <= 1'b0;
      dn  <= 1'b0;
    end else if (ctl.wr) begin
      car <= car_next;
      up  <= up_next;
      dn  <= dn_next;
    end
  end

  // decisions run on the updated bits
  assign any_next  = car_next | up_next | dn_next;
  assign above_out = above_in | any_next;
  assign below_out = below_in | any_next;
  assign any_call  = car | up | dn;

  always_comb begin
    res = '0;
    if (sel) begin
      res.above = above_in;
      res.below = below_in;
      unique case (ctl.dir)
        MOVE_UP:   res.stop = car_next | up_next | (dn_next & ~above_in);
        MOVE_DOWN: res.stop = car_next | dn_next | (up_next & ~below_in);
        default:   res.stop = car_next;
      endcase
    end
  end

endmodule

// ===== rtl/core/look_elevator_dispatch.sv =====
// channel   handshake            payload
// in        in_valid/in_ready    command, floor_number, call_kind, travel_dir
// out       out_valid/out_ready  error_flag, stop_here, next_dir
//
// one item per cycle unless in_ready drops; the result appears in the output
// register the cycle after the item is taken, set by the above/below ripple
// through the cell row; reset clears all call bits and out_valid, no clearing
// pass; in_ready drops only while a result waits and out_ready is low
`include "look_elevator_dispatch_defines.svh"

module look_elevator_dispatch
  import lkd_pkg::*;
#(
  parameter int FLOORS = FLOORS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  logic [3:0] floor_number,
  input  logic [1:0] call_kind,
  input  logic [1:0] travel_dir,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       error_flag,
  output logic       stop_here,
  output logic [1:0] next_dir
);

  localparam logic [5:0] FLOORS_W = 6'(FLOORS);

  logic              in_fire;
  logic              in_range;
  logic              bad_kind;
  logic              ok;
  lkd_ctl_t          ctl;
  logic [FLOORS-1:0] sel;
  logic [FLOORS-1:0] above_ch;
  logic [FLOORS-1:0] below_ch;
  logic [FLOORS-1:0] any_vec;
  lkd_res_t          cell_res [FLOORS];
  lkd_res_t          pick;
  logic [1:0]        dir_calc;
  logic              out_err;
  logic              no_decision;
  logic              rejected;
  logic              clear_ok;
  logic              dir_legal;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign in_range = {2'b00, floor_number} < FLOORS_W;
  assign bad_kind = (command == CMD_ADD) && (call_kind == KIND_BAD);
  assign ok       = in_range && !bad_kind;

  assign ctl.wr    = in_fire && ok;
  assign ctl.add   = command == CMD_ADD;
  assign ctl.clear = command == CMD_CLEAR;
  assign ctl.kind  = call_kind;
  assign ctl.dir   = travel_dir;

  // each cell passes "calls above" down and "calls below" up
  for (genvar i = 0; i < FLOORS; i++) begin : g_cell
    logic a_in, b_in;
    if (i == FLOORS - 1) begin : g_top
      assign a_in = 1'b0;
    end else begin : g_mid_a
      assign a_in = above_ch[i+1];
    end
    if (i == 0) begin : g_bot
      assign b_in = 1'b0;
    end else begin : g_mid_b
      assign b_in = below_ch[i-1];
    end
    assign sel[i] = {2'b00, floor_number} == 6'(i);

    lkd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .sel       (sel[i]),
      .above_in  (a_in),
      .below_in  (b_in),
      .above_out (above_ch[i]),
      .below_out (below_ch[i]),
      .any_call  (any_vec[i]),
      .res       (cell_res[i])
    );
  end

  always_comb begin
    pick = '0;
    for (int i = 0; i < FLOORS; i++) begin
      pick = pick | cell_res[i];
    end
  end

  always_comb begin
    if (travel_dir == MOVE_DOWN) begin
      dir_calc = pick.below ? MOVE_DOWN : (pick.above ? MOVE_UP : MOVE_IDLE);
    end else begin
      dir_calc = pick.above ? MOVE_UP : (pick.below ? MOVE_DOWN : MOVE_IDLE);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      error_flag <= !ok;
      stop_here  <= ok && pick.stop;
      next_dir   <= ok ? dir_calc : MOVE_IDLE;
    end
  end

  assign out_err     = out_valid && error_flag;
  assign no_decision = !stop_here && (next_dir == MOVE_IDLE);
  assign rejected    = in_fire && !ok;
  assign clear_ok    = in_fire && ok && (command == CMD_CLEAR);
  assign dir_legal   = (next_dir == MOVE_IDLE) || (next_dir == MOVE_UP) ||
                       (next_dir == MOVE_DOWN);

  `LKD_ASSERT_SAME(a_err_quiet, out_err, no_decision, "error item carries a decision")
  `LKD_ASSERT_NEXT(a_err_keeps, rejected, $stable(any_vec), "rejected item changed a call")
  `LKD_ASSERT_NEXT(a_clear_nostop, clear_ok, !stop_here, "stop on a cleared floor")
  `LKD_ASSERT_SAME(a_dir_code, out_valid, dir_legal, "unused direction code")

endmodule

// ===== bench/look_elevator_dispatch_tb.sv =====
module look_elevator_dispatch_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lkd_pkg::*;

  localparam int NUM_FLOORS = FLOORS_DEF;
  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam logic [1:0] MOVE_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD_AT = 150;
  localparam int LONG_HOLD_LEN = 80;

  typedef struct packed {
    logic [1:0] cmd;
    logic [3:0] level;
    logic [1:0] kind;
    logic [1:0] dir;
  } call_item_t;

  typedef struct packed {
    logic       err;
    logic       stop;
    logic [1:0] dir;
  } decision_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] command = CMD_QUERY;
  logic [3:0] floor_number = '0;
  logic [1:0] call_kind = KIND_CAR;
  logic [1:0] travel_dir = MOVE_IDLE;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       error_flag;
  logic       stop_here;
  logic [1:0] next_dir;

  // predictor copy of the call masks
  logic [NUM_FLOORS-1:0] car_calls = '0;
  logic [NUM_FLOORS-1:0] up_calls = '0;
  logic [NUM_FLOORS-1:0] down_calls = '0;

  call_item_t pending_calls[$];
  decision_t  expected_decisions[$];

  int send_idle_pct = 18;
  int recv_idle_pct = 54;
  int err_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  look_elevator_dispatch DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .floor_number (floor_number),
    .call_kind    (call_kind),
    .travel_dir   (travel_dir),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .error_flag   (error_flag),
    .stop_here    (stop_here),
    .next_dir     (next_dir)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // applies one item to the mask copy and returns the LOOK answer
  function automatic decision_t look_decision(input call_item_t it);
    decision_t             r;
    logic [NUM_FLOORS-1:0] all_calls;
    logic                  ahead_up;
    logic                  ahead_down;
    int                    f;
    r = '{err: 1'b1, stop: 1'b0, dir: MOVE_IDLE};
    if (it.level >= NUM_FLOORS) return r;
    f = it.level;
    if (it.cmd == CMD_ADD) begin
      case (it.kind)
        KIND_CAR:  car_calls[f] = 1'b1;
        KIND_UP:   up_calls[f] = 1'b1;
        KIND_DOWN: down_calls[f] = 1'b1;
        default:   return r;
      endcase
    end else if (it.cmd == CMD_CLEAR) begin
      car_calls[f] = 1'b0;
      up_calls[f] = 1'b0;
      down_calls[f] = 1'b0;
    end
    all_calls = car_calls | up_calls | down_calls;
    ahead_up = 1'b0;
    ahead_down = 1'b0;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      if (i > f) ahead_up |= all_calls[i];
      if (i < f) ahead_down |= all_calls[i];
    end
    r.err = 1'b0;
    r.stop = car_calls[f];
    if (it.dir == MOVE_UP) begin
      r.stop |= up_calls[f] | (down_calls[f] & !ahead_up);
    end else if (it.dir == MOVE_DOWN) begin
      r.stop |= down_calls[f] | (up_calls[f] & !ahead_down);
    end
    if (it.dir == MOVE_DOWN) begin
      r.dir = ahead_down ? MOVE_DOWN : (ahead_up ? MOVE_UP : MOVE_IDLE);
    end else begin
      r.dir = ahead_up ? MOVE_UP : (ahead_down ? MOVE_DOWN : MOVE_IDLE);
    end
    return r;
  endfunction

  function automatic call_item_t random_call();
    call_item_t c;
    int         sel;
    sel = $urandom_range(99);
    if (sel < 45) c.cmd = CMD_ADD;
    else if (sel < 70) c.cmd = CMD_CLEAR;
    else if (sel < 92) c.cmd = CMD_QUERY;
    else c.cmd = CMD_SPARE;
    // mostly real floors, now and then a floor past the top, up to 15
    if ($urandom_range(9) == 0) c.level = 4'($urandom_range(15, NUM_FLOORS));
    else c.level = 4'($urandom_range(NUM_FLOORS - 1));
    if ($urandom_range(9) == 0) c.kind = KIND_BAD;
    else c.kind = 2'($urandom_range(2));
    c.dir = 2'($urandom_range(3));
    return c;
  endfunction

  task automatic push_call(input logic [1:0] cmd, input int level,
                           input logic [1:0] kind, input logic [1:0] dir);
    pending_calls.push_back('{cmd: cmd, level: 4'(level), kind: kind, dir: dir});
  endtask

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic wait_all_done();
    while (pending_calls.size() != 0 || expected_decisions.size() != 0) @(negedge clk);
  endtask

  // sender
  always @(posedge clk) begin : send_proc
    call_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_calls.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_calls.pop_front();
        command <= it.cmd;
        floor_number <= it.level;
        call_kind <= it.kind;
        travel_dir <= it.dir;
        in_valid <= 1'b1;
        // items are taken in order, so predicting here keeps the mask order
        expected_decisions.push_back(look_decision(it));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver, with one long hold once enough results have come
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= LONG_HOLD_LEN;
      long_hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // checker
  always @(posedge clk) begin : check_proc
    decision_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (expected_decisions.size() == 0) begin
        report_mismatch("result with no item pending");
      end else begin
        want = expected_decisions.pop_front();
        if (error_flag !== want.err)
          report_mismatch($sformatf("error_flag %b want %b", error_flag, want.err));
        if (stop_here !== want.stop)
          report_mismatch($sformatf("stop_here %b want %b", stop_here, want.stop));
        if (next_dir !== want.dir)
          report_mismatch($sformatf("next_dir %0d want %0d", next_dir, want.dir));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("look_elevator_dispatch_tb failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty building, top and bottom floors, opposite hall calls
    push_call(CMD_QUERY, 0, KIND_CAR, MOVE_IDLE);
    push_call(CMD_ADD, NUM_FLOORS - 1, KIND_CAR, MOVE_UP);
    push_call(CMD_ADD, 0, KIND_UP, MOVE_DOWN);
    push_call(CMD_ADD, NUM_FLOORS - 1, KIND_DOWN, MOVE_UP);
    push_call(CMD_ADD, 3, KIND_DOWN, MOVE_UP);
    push_call(CMD_CLEAR, NUM_FLOORS - 1, KIND_BAD, MOVE_UP);
    push_call(CMD_QUERY, 3, KIND_BAD, MOVE_UP);
    push_call(CMD_ADD, 5, KIND_UP, MOVE_DOWN);
    push_call(CMD_QUERY, 5, KIND_CAR, MOVE_DOWN);
    push_call(CMD_QUERY, 5, KIND_DOWN, MOVE_UP);
    // rejected items leave the masks alone
    push_call(CMD_ADD, 2, KIND_BAD, MOVE_UP);
    push_call(CMD_ADD, NUM_FLOORS, KIND_CAR, MOVE_DOWN);
    push_call(CMD_QUERY, 15, KIND_UP, MOVE_UP);
    push_call(CMD_CLEAR, 12, KIND_DOWN, MOVE_IDLE);
    // spare command and direction codes
    push_call(CMD_SPARE, 3, KIND_BAD, MOVE_SPARE);
    push_call(CMD_ADD, 3, KIND_CAR, MOVE_SPARE);
    push_call(CMD_QUERY, 3, KIND_CAR, MOVE_IDLE);
    push_call(CMD_QUERY, 3, KIND_CAR, MOVE_DOWN);
    push_call(CMD_CLEAR, 0, KIND_UP, MOVE_DOWN);
    push_call(CMD_CLEAR, 3, KIND_CAR, MOVE_UP);
    push_call(CMD_CLEAR, 5, KIND_DOWN, MOVE_DOWN);
    push_call(CMD_QUERY, 4, KIND_CAR, MOVE_IDLE);
    wait_all_done();

    // each phase starts only after the previous one has fully drained
    for (int i = 0; i < 350; i++) pending_calls.push_back(random_call());
    wait_all_done();
    send_idle_pct = 54;
    recv_idle_pct = 18;
    for (int i = 0; i < 350; i++) pending_calls.push_back(random_call());
    wait_all_done();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 300; i++) pending_calls.push_back(random_call());
    wait_all_done();

    repeat (5) @(negedge clk);
    if (expected_decisions.size() != 0)
      report_mismatch($sformatf("%0d results never came", expected_decisions.size()));
    if (err_count == 0) begin
      $display("look_elevator_dispatch_tb passed");
    end else begin
      $display("look_elevator_dispatch_tb failed");
    end
    $finish;
  end

endmodule
